// ----- src/cdq_pkg.sv -----
// ----------------------------------------------------------------------------
// cdq_pkg
// Shared types and constants of the circular deque: command and status codes,
// the capacity register format and the descriptor passed from front to back.
// ----------------------------------------------------------------------------
package cdq_pkg;

  // Capacity register width and its value after reset.
  localparam int CAP_W = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [2:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_DUMP_FRONT = 3'd4,
    CMD_DUMP_BACK  = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  // Control part of one queued operation for the back end.
  typedef struct packed {
    logic    wr;
    logic    rd;
    status_t status;
    logic    is_empty;
    logic    is_full;
    logic    last;
  } cdq_meta_t;

endpackage

// ----- src/cdq_front.sv -----
// ----------------------------------------------------------------------------
// cdq_front
// Command front end: owns the deque indices and capacity, decodes requests and
// issues storage ops to the queue, expanding dumps one per cycle when ready.
// ----------------------------------------------------------------------------
module cdq_front import cdq_pkg::*; #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32,
  localparam int IDX_W     = $clog2(DEPTH),
  localparam int CNT_W     = $clog2(DEPTH + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [2:0]            in_cmd,
  input  logic [DATA_WIDTH-1:0] in_push_value,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CAP_W-1:0]      cfg_capacity,
  output logic                  q_valid,
  input  logic                  q_ready,
  output cdq_meta_t             q_meta,
  output logic [IDX_W-1:0]      q_addr,
  output logic [DATA_WIDTH-1:0] q_wdata
);

  localparam logic [CNT_W-1:0] CAP_RST =
    (int'(CAP_RESET) > DEPTH) ? CNT_W'(DEPTH) : CNT_W'(CAP_RESET);

  logic [CNT_W-1:0] cap_r,   cap_nxt;
  logic [IDX_W-1:0] front_r, front_nxt;
  logic [IDX_W-1:0] rear_r,  rear_nxt;
  logic             empty_r, empty_nxt;
  logic             busy_r,  busy_nxt;
  logic             back_r,  back_nxt;
  logic [IDX_W-1:0] idx_r,   idx_nxt;
  logic [CNT_W-1:0] n_r,     n_nxt;
  logic             cur_full;
  logic             dump_end;

  function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i,
                                                input logic [CNT_W-1:0] cap);
    logic [CNT_W-1:0] inc;
    inc = CNT_W'(i) + CNT_W'(1);
    return (inc >= cap) ? '0 : IDX_W'(inc);
  endfunction

  function automatic logic [IDX_W-1:0] prev_idx(input logic [IDX_W-1:0] i,
                                                input logic [CNT_W-1:0] cap);
    logic [CNT_W-1:0] dec;
    dec = cap - CNT_W'(1);
    return (i == '0) ? IDX_W'(dec) : i - IDX_W'(1);
  endfunction

  function automatic logic full_of(input logic empty, input logic [IDX_W-1:0] f,
                                   input logic [IDX_W-1:0] r,
                                   input logic [CNT_W-1:0] cap);
    return !empty && (next_idx(r, cap) == f);
  endfunction

  assign in_ready  = !busy_r && q_ready;
  assign cfg_ready = !busy_r;
  assign cur_full  = full_of(empty_r, front_r, rear_r, cap_r);

  always_comb begin
    cap_nxt   = cap_r;
    front_nxt = front_r;
    rear_nxt  = rear_r;
    empty_nxt = empty_r;
    busy_nxt  = busy_r;
    back_nxt  = back_r;
    idx_nxt   = idx_r;
    n_nxt     = n_r;
    q_valid   = 1'b0;
    q_meta    = '{wr: 1'b0, rd: 1'b0, status: STAT_OK, is_empty: empty_r,
                  is_full: cur_full, last: 1'b1};
    q_addr    = '0;
    q_wdata   = in_push_value;
    dump_end  = 1'b0;

    if (busy_r) begin
      // One stored entry per cycle when q_ready; the deque is left as it is.
      dump_end = (back_r ? (idx_r == front_r) : (idx_r == rear_r)) ||
                 (n_r + CNT_W'(1) == cap_r);
      if (q_ready) begin
        q_valid     = 1'b1;
        q_meta.rd   = 1'b1;
        q_meta.last = dump_end;
        q_addr      = idx_r;
        if (dump_end) begin
          busy_nxt = 1'b0;
        end else begin
          idx_nxt = back_r ? prev_idx(idx_r, cap_r) : next_idx(idx_r, cap_r);
          n_nxt   = n_r + CNT_W'(1);
        end
      end
    end else if (in_valid && q_ready) begin
      q_valid = 1'b1;
      unique case (cmd_t'(in_cmd))
        CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
          if (cur_full) begin
            q_meta.status = STAT_FULL;
          end else begin
            q_meta.wr = 1'b1;
            if (empty_r) begin
              front_nxt = '0;
              rear_nxt  = '0;
              empty_nxt = 1'b0;
              q_addr    = '0;
            end else if (cmd_t'(in_cmd) == CMD_PUSH_FRONT) begin
              front_nxt = prev_idx(front_r, cap_r);
              q_addr    = front_nxt;
            end else begin
              rear_nxt = next_idx(rear_r, cap_r);
              q_addr   = rear_nxt;
            end
          end
        end
        CMD_POP_FRONT, CMD_POP_BACK: begin
          if (empty_r) begin
            q_meta.status = STAT_EMPTY;
          end else begin
            q_meta.rd = 1'b1;
            q_addr    = (cmd_t'(in_cmd) == CMD_POP_FRONT) ? front_r : rear_r;
            if (front_r == rear_r) begin
              front_nxt = '0;
              rear_nxt  = '0;
              empty_nxt = 1'b1;
            end else if (cmd_t'(in_cmd) == CMD_POP_FRONT) begin
              front_nxt = next_idx(front_r, cap_r);
            end else begin
              rear_nxt = prev_idx(rear_r, cap_r);
            end
          end
        end
        CMD_DUMP_FRONT, CMD_DUMP_BACK: begin
          if (empty_r) begin
            q_meta.status = STAT_EMPTY;
          end else begin
            // Entries are issued from the busy state that this sets.
            q_valid  = 1'b0;
            busy_nxt = 1'b1;
            back_nxt = (cmd_t'(in_cmd) == CMD_DUMP_BACK);
            idx_nxt  = (cmd_t'(in_cmd) == CMD_DUMP_BACK) ? rear_r : front_r;
            n_nxt    = '0;
          end
        end
        default: begin
        end
      endcase
      q_meta.is_empty = empty_nxt;
      q_meta.is_full  = full_of(empty_nxt, front_nxt, rear_nxt, cap_r);
    end

    // A capacity write empties the deque; stored data is kept.
    if (cfg_valid && cfg_ready) begin
      if (cfg_capacity == '0) begin
        cap_nxt = CNT_W'(1);
      end else if (int'(cfg_capacity) > DEPTH) begin
        cap_nxt = CNT_W'(DEPTH);
      end else begin
        cap_nxt = CNT_W'(cfg_capacity);
      end
      front_nxt = '0;
      rear_nxt  = '0;
      empty_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r   <= CAP_RST;
      front_r <= '0;
      rear_r  <= '0;
      empty_r <= 1'b1;
      busy_r  <= 1'b0;
      back_r  <= 1'b0;
      idx_r   <= '0;
      n_r     <= '0;
    end else begin
      cap_r   <= cap_nxt;
      front_r <= front_nxt;
      rear_r  <= rear_nxt;
      empty_r <= empty_nxt;
      busy_r  <= busy_nxt;
      back_r  <= back_nxt;
      idx_r   <= idx_nxt;
      n_r     <= n_nxt;
    end
  end

endmodule

// ----- src/cdq_queue.sv -----
// ----------------------------------------------------------------------------
// cdq_queue
// Two-entry first-in first-out buffer between the front and back ends; it
// takes one request per cycle unless full, gives one per cycle unless empty,
// and its ready does not depend on the reading side.
// ----------------------------------------------------------------------------
module cdq_queue import cdq_pkg::*; #(
  parameter int WIDTH = 48
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  logic [WIDTH-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_ready,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] slot_r [2];
  logic             wr_ptr_r, wr_ptr_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic [1:0]       count_r,  count_nxt;
  logic             push, pop;

  assign wr_ready = (count_r != 2'd2);
  assign rd_valid = (count_r != 2'd0);
  assign rd_data  = slot_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// ----- src/cdq_back.sv -----
// ----------------------------------------------------------------------------
// cdq_back
// Storage back end: holds the slot memory, carries out queued writes and reads
// in order and presents each result in an output register.
// ----------------------------------------------------------------------------
module cdq_back import cdq_pkg::*; #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32,
  localparam int IDX_W     = $clog2(DEPTH)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  output logic                  q_ready,
  input  cdq_meta_t             q_meta,
  input  logic [IDX_W-1:0]      q_addr,
  input  logic [DATA_WIDTH-1:0] q_wdata,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [DATA_WIDTH-1:0] out_data,
  output cdq_meta_t             out_meta
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic                  out_valid_r, out_valid_nxt;
  logic [DATA_WIDTH-1:0] data_r;
  cdq_meta_t             meta_r;
  logic                  take;

  // The output register is refilled as soon as its result has gone.
  assign q_ready   = !out_valid_r || out_ready;
  assign take      = q_valid && q_ready;
  assign out_valid = out_valid_r;
  assign out_data  = data_r;
  assign out_meta  = meta_r;

  always_comb begin
    out_valid_nxt = take ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      if (q_meta.wr) begin
        mem[q_addr] <= q_wdata;
      end
      data_r <= q_meta.rd ? mem[q_addr] : '0;
      meta_r <= q_meta;
    end
  end

endmodule

// ----- src/circular_deque.sv -----
// ----------------------------------------------------------------------------
// circular_deque
// Double-ended queue in a circular slot store with a configurable capacity.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on in_valid/in_ready with a command and a push value. Each
//   push, pop or unknown command gives one result; a dump of a non-empty deque
//   gives one result per stored entry, with out_last on the final one, and a
//   dump of an empty deque one result with empty status. Every result shows
//   the empty and full flags as they stand after its request.
//   Pushes and pops are taken one per cycle while in_ready is high; a result
//   passes through the two-entry queue and then the back end's output
//   register before it appears on the outputs. A dump holds the input until
//   its last entry is issued, one slot read per cycle while the queue is
//   ready, by the front end's dump counter.
//   A two-entry queue separates the command front end from the memory back
//   end, so requests keep being accepted while a result waits in the output
//   register; a stalled receiver backs the queue up and then drops in_ready.
//   cfg_capacity sets the number of slots in use (zero acts as one, values
//   above DEPTH as DEPTH) and empties the deque; cfg_ready is low during a
//   dump. Reset empties the deque and sets the capacity to 16, capped at
//   DEPTH; slot contents are undefined until written.
// ----------------------------------------------------------------------------
module circular_deque import cdq_pkg::*; #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [2:0]                   in_cmd,
  input  logic signed [DATA_WIDTH-1:0] in_push_value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [DATA_WIDTH-1:0] out_data_value,
  output logic [1:0]                   out_status,
  output logic                         out_is_empty,
  output logic                         out_is_full,
  output logic                         out_last,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [CAP_W-1:0]             cfg_capacity
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int Q_W   = $bits(cdq_meta_t) + IDX_W + DATA_WIDTH;

  logic                  fq_valid, fq_ready;
  cdq_meta_t             fq_meta;
  logic [IDX_W-1:0]      fq_addr;
  logic [DATA_WIDTH-1:0] fq_wdata;
  logic                  qb_valid, qb_ready;
  logic [Q_W-1:0]        qb_data;
  cdq_meta_t             qb_meta;
  logic [IDX_W-1:0]      qb_addr;
  logic [DATA_WIDTH-1:0] qb_wdata;
  logic [DATA_WIDTH-1:0] res_data;
  cdq_meta_t             res_meta;

  cdq_front #(.DEPTH(DEPTH), .DATA_WIDTH(DATA_WIDTH)) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_cmd        (in_cmd),
    .in_push_value (in_push_value),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_capacity  (cfg_capacity),
    .q_valid       (fq_valid),
    .q_ready       (fq_ready),
    .q_meta        (fq_meta),
    .q_addr        (fq_addr),
    .q_wdata       (fq_wdata)
  );

  cdq_queue #(.WIDTH(Q_W)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fq_valid),
    .wr_ready (fq_ready),
    .wr_data  ({fq_meta, fq_addr, fq_wdata}),
    .rd_valid (qb_valid),
    .rd_ready (qb_ready),
    .rd_data  (qb_data)
  );

  assign {qb_meta, qb_addr, qb_wdata} = qb_data;

  cdq_back #(.DEPTH(DEPTH), .DATA_WIDTH(DATA_WIDTH)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (qb_valid),
    .q_ready   (qb_ready),
    .q_meta    (qb_meta),
    .q_addr    (qb_addr),
    .q_wdata   (qb_wdata),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (res_data),
    .out_meta  (res_meta)
  );

  assign out_data_value = res_data;
  assign out_status     = res_meta.status;
  assign out_is_empty   = res_meta.is_empty;
  assign out_is_full    = res_meta.is_full;
  assign out_last       = res_meta.last;

endmodule

// ----- src/cdq_checker.sv -----
// ----------------------------------------------------------------------------
// cdq_checker
// Port-level checks of the circular deque's result stream, bound to the top.
// ----------------------------------------------------------------------------
module cdq_checker import cdq_pkg::*; #(
  parameter int DATA_WIDTH = 32
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [DATA_WIDTH-1:0] out_data_value,
  input logic [1:0]            out_status,
  input logic                  out_is_empty,
  input logic                  out_is_full,
  input logic                  out_last
);

  // A result that is not taken must stay put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data_value) &&
                                $stable(out_status) && $stable(out_last))
    else $error("result changed while stalled");

  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_is_empty && out_is_full))
    else $error("deque reported both empty and full");

  // A rejected push leaves the deque full and returns no data.
  a_full_push: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STAT_FULL |-> out_is_full && out_last &&
                                             out_data_value == '0)
    else $error("full status without full deque");

  // An empty status ends its request and leaves the deque empty.
  a_empty_res: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STAT_EMPTY |-> out_is_empty && out_last &&
                                              out_data_value == '0)
    else $error("empty status without empty deque");

endmodule

bind circular_deque cdq_checker #(.DATA_WIDTH(DATA_WIDTH)) u_cdq_checker (.*);
